>>> rtl/jbt_pkg.sv
// shared types, codes and byte classification for the json byte tokenizer
`default_nettype none

package jbt_pkg;

  // token type codes
  typedef enum logic [3:0] {
    TOK_ERROR   = 4'd0,
    TOK_LBRACE  = 4'd1,
    TOK_RBRACE  = 4'd2,
    TOK_LBRACK  = 4'd3,
    TOK_RBRACK  = 4'd4,
    TOK_STRING  = 4'd5,
    TOK_NUMBER  = 4'd6,
    TOK_TRUE    = 4'd7,
    TOK_FALSE   = 4'd8,
    TOK_NULL    = 4'd9,
    TOK_COLON   = 4'd10,
    TOK_COMMA   = 4'd11,
    TOK_END     = 4'd12
  } tok_type_e;

  // characters the lexer looks at
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_E_LO   = 8'h65;
  localparam logic [7:0] CH_E_UP   = 8'h45;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;

  // bytes dropped after a literal's first letter
  localparam logic [2:0] SKIP_SHORT = 3'd4 - 3'd1;
  localparam logic [2:0] SKIP_LONG  = 3'd5 - 3'd1;

  // queue between front and back, in token bundles
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // most tokens one byte can cause
  localparam int unsigned MAX_TOKENS = 3;

  // one token as it leaves the block
  typedef struct packed {
    tok_type_e   ttype;
    logic [31:0] start;
    logic [31:0] length;
  } token_t;

  // all tokens caused by one input byte
  typedef struct packed {
    logic [1:0]               count;
    token_t [MAX_TOKENS-1:0]  tok;
  } bundle_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // what a byte means between tokens
  typedef struct packed {
    logic      emit;
    tok_type_e ttype;
    logic      to_str;
    logic      to_num;
    logic      to_skip;
    logic [2:0] skip;
  } idle_cls_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic idle_cls_t classify_idle(input logic [7:0] c);
    idle_cls_t r;
    r = '{emit: 1'b0, ttype: TOK_ERROR, to_str: 1'b0, to_num: 1'b0,
          to_skip: 1'b0, skip: 3'd0};
    case (c)
      CH_LBRACE: begin r.emit = 1'b1; r.ttype = TOK_LBRACE; end
      CH_RBRACE: begin r.emit = 1'b1; r.ttype = TOK_RBRACE; end
      CH_LBRACK: begin r.emit = 1'b1; r.ttype = TOK_LBRACK; end
      CH_RBRACK: begin r.emit = 1'b1; r.ttype = TOK_RBRACK; end
      CH_COLON:  begin r.emit = 1'b1; r.ttype = TOK_COLON; end
      CH_COMMA:  begin r.emit = 1'b1; r.ttype = TOK_COMMA; end
      CH_QUOTE:  r.to_str = 1'b1;
      CH_T: begin
        r.emit = 1'b1; r.ttype = TOK_TRUE; r.to_skip = 1'b1; r.skip = SKIP_SHORT;
      end
      CH_F: begin
        r.emit = 1'b1; r.ttype = TOK_FALSE; r.to_skip = 1'b1; r.skip = SKIP_LONG;
      end
      CH_N: begin
        r.emit = 1'b1; r.ttype = TOK_NULL; r.to_skip = 1'b1; r.skip = SKIP_SHORT;
      end
      default: begin
        if ((c == CH_MINUS) || is_digit(c)) begin
          r.to_num = 1'b1;
        end else if (!is_space(c)) begin
          r.emit = 1'b1;
          r.ttype = TOK_ERROR;
        end
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/jbt_front.sv
// front end: lexer state machine that turns each byte into a token bundle
`default_nettype none

module jbt_front #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        in_byte_i,
  input  wire logic              end_of_input_i,
  input  wire jbt_pkg::q_status_t q_status_i,
  output logic                   push_o,
  output jbt_pkg::bundle_t       bundle_o
);
  import jbt_pkg::*;

  typedef enum logic [7:0] {
    M_IDLE     = 8'b0000_0001,
    M_STR      = 8'b0000_0010,
    M_STR_ESC  = 8'b0000_0100,
    M_NUM_INT  = 8'b0000_1000,
    M_NUM_FRAC = 8'b0001_0000,
    M_NUM_EXP0 = 8'b0010_0000,
    M_NUM_EXPD = 8'b0100_0000,
    M_SKIP     = 8'b1000_0000
  } lexer_mode_e;

  lexer_mode_e            mode_q, mode_d;
  logic [2:0]             skip_q, skip_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] cs_q, cs_d;
  logic [OFFSET_BITS-1:0] nxt;
  logic                   accept;
  idle_cls_t              cls;
  bundle_t                bnd;
  logic [1:0]             n;
  logic                   run_idle;
  logic                   num_take;
  logic                   num_mode;
  logic [2:0]             skip_dec;

  // offset reduced to the 32-bit result field
  function automatic logic [31:0] to32(input logic [OFFSET_BITS-1:0] x);
    logic [OFFSET_BITS+31:0] w;
    w = {32'd0, x};
    return w[31:0];
  endfunction

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign nxt        = pos_q + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
  assign cls        = classify_idle(in_byte_i);

  // lexing of one byte
  always_comb begin
    mode_d   = mode_q;
    skip_d   = skip_q;
    cs_d     = cs_q;
    pos_d    = nxt;
    bnd      = '0;
    n        = 2'd0;
    run_idle = 1'b0;
    num_take = 1'b0;
    skip_dec = 3'd0;
    case (mode_q)
      M_STR: begin
        if (in_byte_i == CH_BSLASH) begin
          mode_d = M_STR_ESC;
        end else if (in_byte_i == CH_QUOTE) begin
          bnd.tok[n] = '{ttype: TOK_STRING, start: to32(cs_q), length: to32(pos_q - cs_q)};
          n = n + 2'd1;
          mode_d = M_IDLE;
        end
      end
      M_STR_ESC: mode_d = M_STR;
      M_NUM_INT, M_NUM_FRAC, M_NUM_EXP0, M_NUM_EXPD: begin
        case (mode_q)
          M_NUM_INT: begin
            if (is_digit(in_byte_i)) begin
              num_take = 1'b1;
            end else if (in_byte_i == CH_DOT) begin
              num_take = 1'b1; mode_d = M_NUM_FRAC;
            end else if ((in_byte_i == CH_E_LO) || (in_byte_i == CH_E_UP)) begin
              num_take = 1'b1; mode_d = M_NUM_EXP0;
            end
          end
          M_NUM_FRAC: begin
            if (is_digit(in_byte_i)) begin
              num_take = 1'b1;
            end else if ((in_byte_i == CH_E_LO) || (in_byte_i == CH_E_UP)) begin
              num_take = 1'b1; mode_d = M_NUM_EXP0;
            end
          end
          M_NUM_EXP0: begin
            if ((in_byte_i == CH_PLUS) || (in_byte_i == CH_MINUS) || is_digit(in_byte_i)) begin
              num_take = 1'b1; mode_d = M_NUM_EXPD;
            end
          end
          default: num_take = is_digit(in_byte_i);
        endcase
        if (!num_take) begin
          bnd.tok[n] = '{ttype: TOK_NUMBER, start: to32(cs_q), length: to32(pos_q - cs_q)};
          n = n + 2'd1;
          run_idle = 1'b1;
        end
      end
      M_SKIP: begin
        skip_dec = (skip_q != 3'd0) ? (skip_q - 3'd1) : 3'd0;
        skip_d   = skip_dec;
        if (skip_dec == 3'd0) mode_d = M_IDLE;
      end
      default: run_idle = 1'b1;
    endcase

    // byte handled as the start of a new token
    if (run_idle) begin
      mode_d = M_IDLE;
      if (cls.emit) begin
        bnd.tok[n] = '{ttype: cls.ttype, start: to32(pos_q), length: 32'd0};
        n = n + 2'd1;
      end
      if (cls.to_str) begin
        cs_d = nxt; mode_d = M_STR;
      end
      if (cls.to_num) begin
        cs_d = pos_q; mode_d = M_NUM_INT;
      end
      if (cls.to_skip) begin
        skip_d = cls.skip; mode_d = M_SKIP;
      end
    end

    // end of document: flush pending content, then end token, then reset
    if (end_of_input_i) begin
      num_mode = (mode_d == M_NUM_INT) || (mode_d == M_NUM_FRAC) ||
                 (mode_d == M_NUM_EXP0) || (mode_d == M_NUM_EXPD);
      if ((mode_d == M_STR) || (mode_d == M_STR_ESC)) begin
        bnd.tok[n] = '{ttype: TOK_STRING, start: to32(cs_d), length: to32(nxt - cs_d)};
        n = n + 2'd1;
      end else if (num_mode) begin
        bnd.tok[n] = '{ttype: TOK_NUMBER, start: to32(cs_d), length: to32(nxt - cs_d)};
        n = n + 2'd1;
      end
      bnd.tok[n] = '{ttype: TOK_END, start: to32(nxt), length: 32'd0};
      n = n + 2'd1;
      mode_d = M_IDLE;
      skip_d = 3'd0;
      pos_d  = '0;
      cs_d   = '0;
    end else begin
      num_mode = 1'b0;
    end
    bnd.count = n;
  end

  assign push_o   = accept && (n != 2'd0);
  assign bundle_o = bnd;

  // lexer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      skip_q <= 3'd0;
      pos_q  <= '0;
      cs_q   <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      skip_q <= skip_d;
      pos_q  <= pos_d;
      cs_q   <= cs_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/jbt_queue.sv
// short bundle queue that decouples lexer front from token output back
`default_nettype none

module jbt_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire jbt_pkg::bundle_t  push_data_i,
  input  wire logic              pop_i,
  output jbt_pkg::bundle_t       head_o,
  output jbt_pkg::q_status_t     status_o
);
  import jbt_pkg::*;

  bundle_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_q, wr_d;
  logic [QPTR_BITS-1:0] rd_q, rd_d;
  logic [QPTR_BITS:0]   cnt_q, cnt_d;
  logic                 do_push;
  logic                 do_pop;

  assign status_o.full  = (cnt_q == QUEUE_DEPTH[QPTR_BITS:0]);
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = mem_q[rd_q];

  // pointer and fill count update
  always_comb begin
    wr_d  = do_push ? wr_q + {{(QPTR_BITS-1){1'b0}}, 1'b1} : wr_q;
    rd_d  = do_pop  ? rd_q + {{(QPTR_BITS-1){1'b0}}, 1'b1} : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + {{QPTR_BITS{1'b0}}, 1'b1};
    if (!do_push && do_pop) cnt_d = cnt_q - {{QPTR_BITS{1'b0}}, 1'b1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // bundle storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

>>> rtl/jbt_back.sv
// back end: unpacks bundles into single tokens held in an output register
`default_nettype none

module jbt_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire jbt_pkg::bundle_t   head_i,
  input  wire jbt_pkg::q_status_t q_status_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output jbt_pkg::token_t         out_tok_o,
  output logic                    out_last_o
);
  import jbt_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  token_t     tok_q;
  logic       last_q;
  logic       load;
  logic       is_last;

  assign load    = (!valid_q || out_ready_i) && !q_status_i.empty;
  assign is_last = (idx_q == (head_i.count - 2'd1));
  assign pop_o   = load && is_last;

  // walk through the tokens of the head bundle
  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = is_last ? 2'd0 : idx_q + 2'd1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      tok_q  <= head_i.tok[idx_q];
      last_q <= is_last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_tok_o   = tok_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

>>> rtl/json_byte_tokenizer_unit.sv
// top level of the json byte tokenizer: front lexer, bundle queue, token output
//
// channel   dir  tdata                                      tlast
// s_axis    in   [7:0] in_byte                              end_of_input
// m_axis    out  [3:0] token_type, [35:4] token_start,      last_result
//                [67:36] token_length, [71:68] zero
//
// one byte is taken per cycle; the lexer state updates in the same cycle the
// transfer happens. each byte yields zero to three tokens, and the output
// register sends one token per cycle unless stalled, so bytes that cause
// several tokens use one output transfer each. a four-bundle queue lets input
// run ahead while the output stalls; input stalls only when the queue is full.
// reset puts the lexer between tokens at offset zero and empties the queue.
`default_nettype none

module json_byte_tokenizer_unit #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // in_byte
  input  wire logic        s_axis_tlast,   // end_of_input
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // token_type, token_start, token_length, pad
  output logic             m_axis_tlast    // last_result
);
  import jbt_pkg::*;

  q_status_t q_status;
  logic      push;
  logic      pop;
  bundle_t   push_bundle;
  bundle_t   head_bundle;
  token_t    out_tok;

  jbt_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_byte_i      (s_axis_tdata),
    .end_of_input_i (s_axis_tlast),
    .q_status_i     (q_status),
    .push_o         (push),
    .bundle_o       (push_bundle)
  );

  jbt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_bundle),
    .pop_i       (pop),
    .head_o      (head_bundle),
    .status_o    (q_status)
  );

  jbt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_bundle),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_tok_o   (out_tok),
    .out_last_o  (m_axis_tlast)
  );

  // pack the token fields, lowest field first
  assign m_axis_tdata = {4'd0, out_tok.length, out_tok.start, out_tok.ttype};

endmodule

`default_nettype wire
